// ===== sv/hss_pkg.sv =====
package hss_pkg;

  localparam int CNT_W  = 16;
  localparam int TIME_W = 40;
  localparam int PER_W  = 20;
  localparam int RUN_W  = 32;
  localparam int EXP_W  = (CNT_W + PER_W > RUN_W) ? CNT_W + PER_W : RUN_W;
  localparam int SUM_W  = ((TIME_W > EXP_W) ? TIME_W : EXP_W) + 1;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [PER_W-1:0] STEP_PERIOD_RST   = 20'd1250;
  localparam logic [RUN_W-1:0] MAX_RUN_TICKS_RST = 32'd30000000;
  localparam logic [RUN_W-1:0] DUTY_WINDOW_RST   = 32'd300000000;
  localparam logic [RUN_W-1:0] DUTY_BUDGET_RST   = 32'd60000000;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_COUNTED = 2'd1,
    OP_CONT    = 2'd2,
    OP_STOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_DUTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_STEP_PERIOD   = 2'd0,
    REG_MAX_RUN_TICKS = 2'd1,
    REG_DUTY_WINDOW   = 2'd2,
    REG_DUTY_BUDGET   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [PER_W-1:0] step_period;
    logic [RUN_W-1:0] max_run_ticks;
    logic [RUN_W-1:0] duty_window;
    logic [RUN_W-1:0] duty_budget;
  } cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e              op;
    logic             rev;
    logic [CNT_W-1:0] mag;
    logic [EXP_W-1:0] expected;
  } cmd_t;

  typedef struct packed {
    logic [3:0] coils;
    logic       running;
    status_e    status;
  } res_t;

  function automatic logic [3:0] phase_coils(input logic [2:0] idx);
    logic [3:0] c;
    unique case (idx)
      3'd0: c = 4'h1;
      3'd1: c = 4'h3;
      3'd2: c = 4'h2;
      3'd3: c = 4'h6;
      3'd4: c = 4'h4;
      3'd5: c = 4'hC;
      3'd6: c = 4'h8;
      3'd7: c = 4'h9;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/halfstep_stepper_sequencer.sv =====
// results pass the front stage, the command queue and the result queue
// throughput: one item per cycle while full is low; the back end updates the run
//   and duty state per command, the reservation product is formed a stage ahead
// full rises only when the front stage is held and the command queue is full
// reset: asynchronous, coils off, no run, no duty window, registers at defaults
module halfstep_stepper_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        op_i,
  input  logic signed [hss_pkg::CNT_W-1:0]  step_count_i,
  input  logic                              direction_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [3:0]                        coil_mask_o,
  output logic                              moving_o,
  output logic [1:0]                        start_status_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hss_pkg::APB_AW-1:0]        paddr,
  input  logic [hss_pkg::APB_DW-1:0]        pwdata,
  output logic [hss_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);
  import hss_pkg::*;

  cfg_t cfg;
  cmd_t fe_cmd, cq_head;
  logic cq_push, cq_full, cq_pop, cq_empty;

  hss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .step_count_i (step_count_i),
    .direction_i  (direction_i),
    .cfg_i        (cfg),
    .cq_full_i    (cq_full),
    .cq_push_o    (cq_push),
    .cq_cmd_o     (fe_cmd)
  );

  hss_cmd_queue u_cq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .cmd_i   (fe_cmd),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .head_o  (cq_head),
    .empty_o (cq_empty)
  );

  hss_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cq_head),
    .cq_empty_i     (cq_empty),
    .cq_pop_o       (cq_pop),
    .empty          (empty),
    .pop            (pop),
    .coil_mask_o    (coil_mask_o),
    .moving_o       (moving_o),
    .start_status_o (start_status_o)
  );

endmodule

// ===== sv/hss_regs.sv =====
module hss_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hss_pkg::APB_AW-1:0]  paddr,
  input  logic [hss_pkg::APB_DW-1:0]  pwdata,
  output logic [hss_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output hss_pkg::cfg_t               cfg_o
);
  import hss_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_STEP_PERIOD:   cfg_d.step_period   = pwdata[PER_W-1:0];
        REG_MAX_RUN_TICKS: cfg_d.max_run_ticks = pwdata[RUN_W-1:0];
        REG_DUTY_WINDOW:   cfg_d.duty_window   = pwdata[RUN_W-1:0];
        REG_DUTY_BUDGET:   cfg_d.duty_budget   = pwdata[RUN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STEP_PERIOD:   prdata = APB_DW'(cfg_q.step_period);
      REG_MAX_RUN_TICKS: prdata = APB_DW'(cfg_q.max_run_ticks);
      REG_DUTY_WINDOW:   prdata = APB_DW'(cfg_q.duty_window);
      REG_DUTY_BUDGET:   prdata = APB_DW'(cfg_q.duty_budget);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_period   <= STEP_PERIOD_RST;
      cfg_q.max_run_ticks <= MAX_RUN_TICKS_RST;
      cfg_q.duty_window   <= DUTY_WINDOW_RST;
      cfg_q.duty_budget   <= DUTY_BUDGET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/hss_front.sv =====
module hss_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        op_i,
  input  logic signed [hss_pkg::CNT_W-1:0]  step_count_i,
  input  logic                              direction_i,
  input  hss_pkg::cfg_t                     cfg_i,
  input  logic                              cq_full_i,
  output logic                              cq_push_o,
  output hss_pkg::cmd_t                     cq_cmd_o
);
  import hss_pkg::*;

  logic             s_valid_q, s_valid_d;
  cmd_t             s_q, s_d;
  logic             take;
  op_e              op;
  logic             neg;
  logic [CNT_W-1:0] cnt_u, mag;
  logic [PER_W-1:0] eff_period;
  logic [EXP_W-1:0] product;

  assign full      = s_valid_q && cq_full_i;
  assign take      = push && !full;
  assign cq_push_o = s_valid_q && !cq_full_i;
  assign cq_cmd_o  = s_q;
  assign s_valid_d = full ? s_valid_q : push;

  assign op         = op_e'(op_i);
  assign cnt_u      = $unsigned(step_count_i);
  assign neg        = cnt_u[CNT_W-1];
  // most negative count wraps onto itself, which is the magnitude wanted
  assign mag        = neg ? (~cnt_u + CNT_W'(1)) : cnt_u;
  assign eff_period = (cfg_i.step_period == '0) ? PER_W'(1) : cfg_i.step_period;
  assign product    = EXP_W'(mag) * EXP_W'(eff_period);

  always_comb begin
    s_d.op = op;
    unique case (op)
      OP_COUNTED: begin
        s_d.rev      = neg;
        s_d.mag      = mag;
        s_d.expected = product;
      end
      OP_CONT: begin
        s_d.rev      = direction_i;
        s_d.mag      = '0;
        s_d.expected = EXP_W'(cfg_i.max_run_ticks);
      end
      OP_TICK, OP_STOP: begin
        s_d.rev      = 1'b0;
        s_d.mag      = '0;
        s_d.expected = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s_q <= s_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
    end
  end

endmodule

// ===== sv/hss_cmd_queue.sv =====
module hss_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hss_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output hss_pkg::cmd_t head_o,
  output logic          empty_o
);
  import hss_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
    end
  end

endmodule

// ===== sv/hss_back.sv =====
module hss_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hss_pkg::cfg_t cfg_i,
  input  hss_pkg::cmd_t cmd_i,
  input  logic          cq_empty_i,
  output logic          cq_pop_o,
  output logic          empty,
  input  logic          pop,
  output logic [3:0]    coil_mask_o,
  output logic          moving_o,
  output logic [1:0]    start_status_o
);
  import hss_pkg::*;

  // run and duty state
  logic [2:0]        phase_q, phase_d;
  logic [3:0]        coils_q, coils_d;
  logic              run_q, run_d;
  logic              cont_q, cont_d;
  logic              rev_q, rev_d;
  logic [CNT_W-1:0]  steps_q, steps_d;
  logic [PER_W-1:0]  pt_q, pt_d;
  logic [RUN_W-1:0]  re_q, re_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [TIME_W-1:0] ws_q, ws_d;
  logic              wv_q, wv_d;
  logic [TIME_W-1:0] rsv_q, rsv_d;

  // result queue
  res_t       rq_mem_q [2];
  logic       rq_wr_q, rq_rd_q;
  logic [1:0] rq_cnt_q, rq_cnt_d;
  logic       rq_full, rq_pop;
  res_t       res;
  res_t       rq_head;

  logic              exec;
  status_e           status;
  logic [PER_W-1:0]  eff_period;
  logic [PER_W-1:0]  pt_inc;
  logic [RUN_W-1:0]  re_inc;
  logic [2:0]        tick_phase, start_phase;
  logic [TIME_W-1:0] win_diff;
  logic              expired;
  logic [SUM_W-1:0]  sum_keep, sum_sel;
  logic              over_keep, over_fresh, over;

  assign rq_full  = (rq_cnt_q == 2'd2);
  assign empty    = (rq_cnt_q == 2'd0);
  assign rq_pop   = pop && !empty;
  assign exec     = !cq_empty_i && !rq_full;
  assign cq_pop_o = exec;

  assign rq_head        = rq_mem_q[rq_rd_q];
  assign coil_mask_o    = rq_head.coils;
  assign moving_o       = rq_head.running;
  assign start_status_o = rq_head.status;

  assign eff_period  = (cfg_i.step_period == '0) ? PER_W'(1) : cfg_i.step_period;
  assign pt_inc      = (pt_q != '1) ? pt_q + PER_W'(1) : pt_q;
  assign re_inc      = (re_q != '1) ? re_q + RUN_W'(1) : re_q;
  assign tick_phase  = phase_q + (rev_q ? 3'd7 : 3'd1);
  assign start_phase = cmd_i.rev ? 3'd7 : 3'd1;

  // window age and both budget checks side by side, then a select
  assign win_diff   = time_q - ws_q;
  assign expired    = !wv_q || (win_diff > TIME_W'(cfg_i.duty_window));
  assign sum_keep   = SUM_W'(rsv_q) + SUM_W'(cmd_i.expected);
  assign over_keep  = sum_keep > SUM_W'(cfg_i.duty_budget);
  assign over_fresh = cmd_i.expected > EXP_W'(cfg_i.duty_budget);
  assign over       = expired ? over_fresh : over_keep;
  assign sum_sel    = expired ? SUM_W'(cmd_i.expected) : sum_keep;

  always_comb begin
    phase_d = phase_q;
    coils_d = coils_q;
    run_d   = run_q;
    cont_d  = cont_q;
    rev_d   = rev_q;
    steps_d = steps_q;
    pt_d    = pt_q;
    re_d    = re_q;
    time_d  = time_q;
    ws_d    = ws_q;
    wv_d    = wv_q;
    rsv_d   = rsv_q;
    status  = ST_OK;
    if (exec) begin
      unique case (cmd_i.op)
        OP_TICK: begin
          time_d = time_q + TIME_W'(1);
          if (run_q) begin
            pt_d = pt_inc;
            re_d = re_inc;
            if (cont_q) begin
              if (re_inc >= cfg_i.max_run_ticks) begin
                coils_d = 4'h0;
                run_d   = 1'b0;
                pt_d    = '0;
              end else if (pt_inc >= eff_period) begin
                pt_d    = '0;
                phase_d = tick_phase;
                coils_d = phase_coils(tick_phase);
              end
            end else if (pt_inc >= eff_period) begin
              pt_d = '0;
              if (steps_q != '0) begin
                phase_d = tick_phase;
                coils_d = phase_coils(tick_phase);
                steps_d = steps_q - CNT_W'(1);
              end else begin
                coils_d = 4'h0;
                run_d   = 1'b0;
              end
            end
          end
        end
        OP_STOP: begin
          coils_d = 4'h0;
          run_d   = 1'b0;
          pt_d    = '0;
        end
        OP_COUNTED, OP_CONT: begin
          if (run_q) begin
            status = ST_BUSY;
          end else if (over) begin
            status = ST_DUTY;
          end else begin
            ws_d    = expired ? time_q : ws_q;
            rsv_d   = sum_sel[TIME_W-1:0];
            wv_d    = 1'b1;
            cont_d  = (cmd_i.op == OP_CONT);
            rev_d   = cmd_i.rev;
            pt_d    = '0;
            re_d    = '0;
            steps_d = '0;
            phase_d = 3'd0;
            coils_d = 4'h0;
            run_d   = 1'b1;
            if (cmd_i.op == OP_CONT) begin
              if (cfg_i.max_run_ticks == '0) begin
                run_d = 1'b0;
              end else begin
                phase_d = start_phase;
                coils_d = phase_coils(start_phase);
              end
            end else if (cmd_i.mag == '0) begin
              run_d = 1'b0;
            end else begin
              phase_d = start_phase;
              coils_d = phase_coils(start_phase);
              steps_d = cmd_i.mag - CNT_W'(1);
            end
          end
        end
      endcase
    end
  end

  assign res = '{coils: coils_d, running: run_d, status: status};

  always_comb begin
    unique case ({exec, rq_pop})
      2'b10:   rq_cnt_d = rq_cnt_q + 2'd1;
      2'b01:   rq_cnt_d = rq_cnt_q - 2'd1;
      default: rq_cnt_d = rq_cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      rq_mem_q[rq_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 3'd0;
      coils_q  <= 4'h0;
      run_q    <= 1'b0;
      cont_q   <= 1'b0;
      rev_q    <= 1'b0;
      steps_q  <= '0;
      pt_q     <= '0;
      re_q     <= '0;
      time_q   <= '0;
      ws_q     <= '0;
      wv_q     <= 1'b0;
      rsv_q    <= '0;
      rq_wr_q  <= 1'b0;
      rq_rd_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      phase_q  <= phase_d;
      coils_q  <= coils_d;
      run_q    <= run_d;
      cont_q   <= cont_d;
      rev_q    <= rev_d;
      steps_q  <= steps_d;
      pt_q     <= pt_d;
      re_q     <= re_d;
      time_q   <= time_d;
      ws_q     <= ws_d;
      wv_q     <= wv_d;
      rsv_q    <= rsv_d;
      rq_cnt_q <= rq_cnt_d;
      if (exec)   rq_wr_q <= !rq_wr_q;
      if (rq_pop) rq_rd_q <= !rq_rd_q;
    end
  end

endmodule

// ===== sv/hss_checker.sv =====
module hss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [3:0] coil_mask_o,
  input logic       moving_o,
  input logic [1:0] start_status_o
);
  import hss_pkg::*;

  // coils are dark whenever no run is active
  a_idle_coils_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !moving_o |-> coil_mask_o == 4'h0)
    else $error("coils driven while idle");

  // an active run always drives one or two coils, as every half-step table entry does
  a_run_coils_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && moving_o |->
      ($countones(coil_mask_o) == 1 || $countones(coil_mask_o) == 2))
    else $error("bad coil pattern during run");

  a_busy_means_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && start_status_o == ST_BUSY |-> moving_o)
    else $error("busy refusal without active run");

  a_duty_means_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && start_status_o == ST_DUTY |-> !moving_o)
    else $error("duty refusal during active run");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(coil_mask_o) && $stable(start_status_o))
    else $error("waiting result changed");

endmodule

bind halfstep_stepper_sequencer hss_checker u_hss_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import hss_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // nibble i holds half-step pattern i, coil A in bit 0
  localparam logic [31:0] HALF_STEP = 32'h98C46231;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic              push = 1'b0;
  logic              full;
  logic [1:0]        op_i = OP_TICK;
  logic [CNT_W-1:0]  step_count_i = '0;
  logic              direction_i = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic [3:0]        coil_mask_o;
  logic              moving_o;
  logic [1:0]        start_status_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  halfstep_stepper_sequencer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .op_i           (op_i),
    .step_count_i   (step_count_i),
    .direction_i    (direction_i),
    .empty          (empty),
    .pop            (pop),
    .coil_mask_o    (coil_mask_o),
    .moving_o       (moving_o),
    .start_status_o (start_status_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // sequencer shadow: configuration
  logic [PER_W-1:0] c_period  = STEP_PERIOD_RST;
  logic [RUN_W-1:0] c_max_run = MAX_RUN_TICKS_RST;
  logic [RUN_W-1:0] c_window  = DUTY_WINDOW_RST;
  logic [RUN_W-1:0] c_budget  = DUTY_BUDGET_RST;

  // sequencer shadow: run and duty state
  logic [2:0]        m_phase = '0;
  logic [3:0]        m_coils = '0;
  bit                m_running, m_cont, m_rev, m_win_valid;
  logic [CNT_W-1:0]  m_steps_left = '0;
  logic [PER_W-1:0]  m_timer = '0;
  logic [RUN_W-1:0]  m_elapsed = '0;
  logic [TIME_W-1:0] m_now = '0;
  logic [TIME_W-1:0] m_win_start = '0;
  logic [TIME_W-1:0] m_reserved = '0;

  res_t drive_q[$];
  res_t want_res;
  bit   calm = 1'b0;
  int   n_err, n_items, n_results, n_started, n_busy, n_duty, n_writes;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout with %0d transactions outstanding", drive_q.size());
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    pop <= calm || ($urandom_range(99) >= 34);
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      n_results++;
      if (drive_q.size() == 0) begin
        $display("%0t unexpected result coils %h motion %b status %0d", $time,
                 coil_mask_o, moving_o, start_status_o);
        n_err++;
      end else begin
        want_res = drive_q.pop_front();
        if (coil_mask_o !== want_res.coils) begin
          $display("%0t coil_mask expected %h actual %h", $time, want_res.coils,
                   coil_mask_o);
          n_err++;
        end
        if (moving_o !== want_res.running) begin
          $display("%0t moving expected %b actual %b", $time, want_res.running,
                   moving_o);
          n_err++;
        end
        if (start_status_o !== want_res.status) begin
          $display("%0t start_status expected %0d actual %0d", $time,
                   want_res.status, start_status_o);
          n_err++;
        end
      end
    end
  end

  function automatic logic [PER_W-1:0] eff_period();
    return (c_period == '0) ? PER_W'(1) : c_period;
  endfunction

  function automatic void step_phase();
    m_phase = m_rev ? m_phase - 3'd1 : m_phase + 3'd1;
    m_coils = HALF_STEP[4*m_phase +: 4];
  endfunction

  function automatic void coils_off();
    m_coils   = '0;
    m_running = 1'b0;
    m_timer   = '0;
  endfunction

  // books on-time against the rolling window, refuses when over budget
  function automatic bit book_duty(logic [63:0] need);
    logic [TIME_W-1:0] ws, acc, age;
    ws  = m_win_start;
    acc = m_reserved;
    age = m_now - m_win_start;
    if (!m_win_valid || age > c_window) begin
      ws  = m_now;
      acc = '0;
    end
    if (64'(acc) + need > 64'(c_budget)) return 1'b0;
    m_win_start = ws;
    m_reserved  = acc + need[TIME_W-1:0];
    m_win_valid = 1'b1;
    return 1'b1;
  endfunction

  function automatic res_t sequence_motor(op_e op, logic [CNT_W-1:0] cnt, logic dir);
    res_t        r;
    status_e     st;
    logic [16:0] mag;
    logic [63:0] need;
    bit          rev;
    st   = ST_OK;
    mag  = '0;
    need = '0;
    rev  = 1'b0;
    case (op)
      OP_TICK: begin
        m_now = m_now + 1'b1;
        if (m_running) begin
          if (m_timer != '1) m_timer = m_timer + 1'b1;
          if (m_elapsed != '1) m_elapsed = m_elapsed + 1'b1;
          if (m_cont) begin
            if (m_elapsed >= c_max_run) begin
              coils_off();
            end else if (m_timer >= eff_period()) begin
              m_timer = '0;
              step_phase();
            end
          end else if (m_timer >= eff_period()) begin
            m_timer = '0;
            if (m_steps_left != '0) begin
              step_phase();
              m_steps_left = m_steps_left - 1'b1;
            end else begin
              coils_off();
            end
          end
        end
      end
      OP_STOP: coils_off();
      default: begin
        if (m_running) begin
          st = ST_BUSY;
        end else begin
          if (op == OP_CONT) begin
            rev  = dir;
            need = 64'(c_max_run);
          end else begin
            rev  = cnt[CNT_W-1];
            mag  = rev ? 17'h10000 - {1'b0, cnt} : {1'b0, cnt};
            need = 64'(mag) * 64'(eff_period());
          end
          if (!book_duty(need)) begin
            st = ST_DUTY;
          end else begin
            m_cont       = (op == OP_CONT);
            m_rev        = rev;
            m_phase      = '0;
            m_timer      = '0;
            m_elapsed    = '0;
            m_steps_left = '0;
            m_coils      = '0;
            m_running    = 1'b1;
            if (op == OP_CONT) begin
              if (c_max_run == '0) coils_off();
              else step_phase();
            end else if (mag == '0) begin
              coils_off();
            end else begin
              step_phase();
              m_steps_left = CNT_W'(mag - 17'd1);
            end
          end
        end
      end
    endcase
    r.coils   = m_coils;
    r.running = m_running;
    r.status  = st;
    return r;
  endfunction

  task automatic send_cmd(op_e op, logic [CNT_W-1:0] cnt, logic dir);
    res_t r;
    if (!calm) begin
      while ($urandom_range(99) < 34) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push         <= 1'b1;
    op_i         <= op;
    step_count_i <= cnt;
    direction_i  <= dir;
    do @(posedge clk_i); while (full);
    r = sequence_motor(op, cnt, dir);
    drive_q.push_back(r);
    n_items++;
    if (op == OP_COUNTED || op == OP_CONT) begin
      case (r.status)
        ST_OK:   n_started++;
        ST_BUSY: n_busy++;
        default: n_duty++;
      endcase
    end
  endtask

  task automatic tick_n(int n);
    repeat (n) send_cmd(OP_TICK, 16'($urandom), 1'($urandom));
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_xfer(bit wr, reg_idx_e idx, logic [APB_DW-1:0] wdata,
                          output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(reg_idx_e idx, logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] got;
    apb_xfer(1'b0, idx, '0, got);
    if (got !== want) begin
      $display("%0t register %s expected %h actual %h", $time, idx.name(), want, got);
      n_err++;
    end
  endtask

  // only written once every transaction in flight has come back
  task automatic set_reg(reg_idx_e idx, logic [APB_DW-1:0] val);
    logic [APB_DW-1:0] unused;
    drain_results();
    apb_xfer(1'b1, idx, val, unused);
    n_writes++;
    case (idx)
      REG_STEP_PERIOD:   c_period  = val[PER_W-1:0];
      REG_MAX_RUN_TICKS: c_max_run = val;
      REG_DUTY_WINDOW:   c_window  = val;
      default:           c_budget  = val;
    endcase
    check_reg(idx, (idx == REG_STEP_PERIOD) ? APB_DW'(val[PER_W-1:0]) : val);
  endtask

  task automatic test_reset_values();
    check_reg(REG_STEP_PERIOD, APB_DW'(STEP_PERIOD_RST));
    check_reg(REG_MAX_RUN_TICKS, MAX_RUN_TICKS_RST);
    check_reg(REG_DUTY_WINDOW, DUTY_WINDOW_RST);
    check_reg(REG_DUTY_BUDGET, DUTY_BUDGET_RST);
    send_cmd(OP_COUNTED, 16'd3, 1'b1);
    tick_n(1);
    send_cmd(OP_CONT, 16'hFFFF, 1'b0);
    send_cmd(OP_STOP, 16'h0, 1'b0);
  endtask

  task automatic test_directed_runs();
    set_reg(REG_STEP_PERIOD, 32'd1);
    set_reg(REG_MAX_RUN_TICKS, 32'd3);
    set_reg(REG_DUTY_WINDOW, 32'd20);
    set_reg(REG_DUTY_BUDGET, 32'd12);
    send_cmd(OP_STOP, 16'h0, 1'b1);          // stop while idle
    send_cmd(OP_COUNTED, 16'd0, 1'b1);       // zero-length run
    send_cmd(OP_COUNTED, 16'd2, 1'b0);
    tick_n(2);                               // ticks with no run active
    send_cmd(OP_COUNTED, 16'hFFFF, 1'b0);    // one step reverse
    send_cmd(OP_COUNTED, 16'd5, 1'b0);       // refused over duty budget
    send_cmd(OP_CONT, 16'd0, 1'b1);          // refused over duty budget
    send_cmd(OP_STOP, 16'h7FFF, 1'b0);
    send_cmd(OP_CONT, 16'h8000, 1'b0);
    tick_n(3);                               // ticks, no run for the runtime cap to end
    send_cmd(OP_CONT, 16'h0, 1'b1);
    send_cmd(OP_STOP, 16'h0, 1'b0);
    send_cmd(OP_COUNTED, 16'h7FFF, 1'b1);    // over budget
    send_cmd(OP_COUNTED, 16'h8000, 1'b0);    // most negative count, over budget
    send_cmd(OP_COUNTED, 16'd6, 1'b0);       // refused over duty budget
    send_cmd(OP_STOP, 16'h0, 1'b0);
    send_cmd(OP_COUNTED, 16'd1, 1'b0);       // nothing refunded, refused
  endtask

  task automatic test_config_extremes();
    set_reg(REG_MAX_RUN_TICKS, 32'd0);
    set_reg(REG_DUTY_WINDOW, 32'd0);
    tick_n(1);
    send_cmd(OP_CONT, 16'h0, 1'b0);          // ends at once without a step
    tick_n(1);
    set_reg(REG_STEP_PERIOD, 32'd0);         // behaves as a period of one
    send_cmd(OP_COUNTED, 16'd2, 1'b0);
    tick_n(2);
    set_reg(REG_STEP_PERIOD, 32'hFFFFF);
    set_reg(REG_MAX_RUN_TICKS, 32'hFFFFFFFF);
    set_reg(REG_DUTY_WINDOW, 32'hFFFFFFFF);
    set_reg(REG_DUTY_BUDGET, 32'hFFFFFFFF);
    send_cmd(OP_COUNTED, 16'hFFFD, 1'b0);
    tick_n(3);
    set_reg(REG_STEP_PERIOD, 32'd2);         // period lowered while running
    tick_n(2);
    send_cmd(OP_CONT, 16'h0, 1'b0);
    send_cmd(OP_STOP, 16'h0, 1'b0);
    send_cmd(OP_CONT, 16'h0, 1'b0);          // whole budget on top of booked time
    set_reg(REG_DUTY_WINDOW, 32'd1);
    tick_n(2);
    send_cmd(OP_CONT, 16'h0, 1'b1);          // window restarts, accepted
    tick_n(1);
    send_cmd(OP_STOP, 16'h0, 1'b0);
    set_reg(REG_DUTY_BUDGET, 32'd0);
    send_cmd(OP_COUNTED, 16'd0, 1'b0);
    send_cmd(OP_COUNTED, 16'd1, 1'b0);
  endtask

  task automatic test_random_runs();
    int               sent0;
    logic [CNT_W-1:0] cnt;
    for (int ph = 0; ph < 6; ph++) begin
      set_reg(REG_STEP_PERIOD, $urandom_range(4, 0));
      set_reg(REG_MAX_RUN_TICKS, $urandom_range(30, 0));
      set_reg(REG_DUTY_WINDOW, $urandom_range(80, 0));
      set_reg(REG_DUTY_BUDGET, $urandom_range(60, 0));
      calm  = (ph == 3);
      sent0 = n_items;
      while (n_items - sent0 < 225) begin
        if ($urandom_range(99) < 80) begin
          // a start followed by a burst of ticks with the odd stop or retry
          if ($urandom_range(1)) begin
            send_cmd(OP_CONT, 16'($urandom), 1'($urandom));
          end else begin
            cnt = 16'($urandom_range(8, 1));
            if ($urandom_range(1)) cnt = -cnt;
            if ($urandom_range(9) == 0) cnt = 16'($urandom);
            send_cmd(OP_COUNTED, cnt, 1'($urandom));
          end
          repeat ($urandom_range(24, 0)) begin
            case ($urandom_range(19))
              0:       send_cmd(OP_STOP, 16'($urandom), 1'($urandom));
              1:       send_cmd(OP_COUNTED, 16'($urandom), 1'($urandom));
              2:       send_cmd(OP_CONT, 16'($urandom), 1'($urandom));
              default: tick_n(1);
            endcase
          end
        end else begin
          send_cmd(op_e'($urandom_range(3)), 16'($urandom), 1'($urandom));
        end
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed_runs();
    test_config_extremes();
    test_random_runs();
    drain_results();
    repeat (8) @(posedge clk_i);
    $display("%0d commands, %0d results checked, %0d register writes", n_items,
             n_results, n_writes);
    $display("starts: %0d accepted, %0d refused busy, %0d refused over duty budget",
             n_started, n_busy, n_duty);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/hss_pkg.sv
sv/hss_regs.sv
sv/hss_front.sv
sv/hss_cmd_queue.sv
sv/hss_back.sv
sv/halfstep_stepper_sequencer.sv
sv/hss_checker.sv
tb/tb_top.sv
